// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// cond must never hold.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// File: rtl/bre_pkg.sv
// Shared types and constants of the BER REAL binary64 encoder.
`timescale 1ns / 1ps

package bre_pkg;

    localparam int MANT_W      = 53;          // binary64 significand digits
    localparam int EXPO_W      = 12;
    localparam int MAX_STRIP   = MANT_W / 8;  // trailing bytes that may be dropped
    localparam int LEN_W       = 3;
    localparam int IDX_W       = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  TAG_REAL   = 8'h09;
    localparam logic [7:0]  HDR_BINARY = 8'h80;
    localparam logic [7:0]  INF_LEN    = 8'h01;
    localparam logic [7:0]  INF_PLUS   = 8'h40;   // minus infinity sets bit 0 (0x41)
    localparam logic [3:0]  SIGN_FILL  = 4'hF;    // top of 0xFF sign byte
    localparam logic [10:0] BEXP_MAX   = 11'h7FF;

    localparam logic signed [EXPO_W-1:0] EXPO_NORM_OFS = 12'sd1075;
    localparam logic signed [EXPO_W-1:0] EXPO_SUB      = -12'sd1074;
    localparam logic signed [EXPO_W-1:0] EXPO_ZERO     = -12'sd53;
    localparam logic signed [EXPO_W-1:0] EXPO_ONE_MIN  = -12'sd128;
    localparam logic signed [EXPO_W-1:0] EXPO_ONE_MAX  = 12'sd127;

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_INF,
        KIND_NAN
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic                       sign;
        logic signed [EXPO_W-1:0]   expo;
        logic [MANT_W-1:0]          mant;
        logic [LEN_W-1:0]           len_m;   // mantissa bytes, 1..7
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: rtl/bre_front.sv
// Front end: accepts binary64 words, classifies and normalizes them in three stages.
`timescale 1ns / 1ps

module bre_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [63:0]       value_bits,
    input  bre_pkg::q_stat_t  q_stat,
    output logic              push,
    output bre_pkg::job_t     push_job
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    bre_pkg::job_t s1_reg, s2_reg, s3_reg;
    bre_pkg::job_t s1_next, s2_next, s3_next;

    assign rdy3     = !v3_reg || !q_stat.full;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign push     = v3_reg && !q_stat.full;
    assign push_job = s3_reg;

    // stage 1: decode, coarse normalize by whole bytes
    always_comb
    begin
        logic [10:0]                         bexp;
        logic [51:0]                         frac;
        logic [bre_pkg::MANT_W-1:0]          mant0;
        logic signed [bre_pkg::EXPO_W-1:0]   expo0;
        logic [2:0]                          cb;
        logic                                run;
        bexp  = value_bits[62:52];
        frac  = value_bits[51:0];
        mant0 = {bexp != '0, frac};
        if (bexp != '0)
            expo0 = $signed({1'b0, bexp}) - bre_pkg::EXPO_NORM_OFS;
        else if (frac != '0)
            expo0 = bre_pkg::EXPO_SUB;
        else
            expo0 = bre_pkg::EXPO_ZERO;
        run = 1'b1;
        cb  = '0;
        for (int i = 0; i < bre_pkg::MAX_STRIP; i++)
        begin
            run = run && (mant0[bre_pkg::MANT_W-1-8*i -: 8] == '0);
            if (run)
                cb = 3'(i + 1);
        end
        if (mant0 == '0)
            cb = '0;
        s1_next.sign  = value_bits[63];
        if (bexp == bre_pkg::BEXP_MAX)
            s1_next.kind = (frac != '0) ? bre_pkg::KIND_NAN : bre_pkg::KIND_INF;
        else
            s1_next.kind = bre_pkg::KIND_NUM;
        s1_next.mant  = mant0 << {cb, 3'b000};
        s1_next.expo  = expo0 - bre_pkg::EXPO_W'({cb, 3'b000});
        s1_next.len_m = '0;
    end

    // stage 2: fine normalize, up to seven bit positions
    always_comb
    begin
        logic [2:0] f;
        logic       run;
        run = 1'b1;
        f   = '0;
        for (int i = 0; i < 7; i++)
        begin
            run = run && !s1_reg.mant[bre_pkg::MANT_W-1-i];
            if (run)
                f = 3'(i + 1);
        end
        if (s1_reg.mant == '0)
            f = '0;
        s2_next      = s1_reg;
        s2_next.mant = s1_reg.mant << f;
        s2_next.expo = s1_reg.expo - bre_pkg::EXPO_W'(f);
    end

    // stage 3: drop trailing zero bytes; a normalized mantissa is 7 bytes long
    always_comb
    begin
        logic [2:0] n;
        logic       run;
        run = 1'b1;
        n   = '0;
        for (int i = 0; i < bre_pkg::MAX_STRIP; i++)
        begin
            run = run && (s2_reg.mant[8*i +: 8] == '0);
            if (run)
                n = 3'(i + 1);
        end
        s3_next       = s2_reg;
        s3_next.mant  = s2_reg.mant >> {n, 3'b000};
        s3_next.expo  = s2_reg.expo + bre_pkg::EXPO_W'({n, 3'b000});
        s3_next.len_m = 3'd7 - n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
        if (rdy3 && v2_reg)
            s3_reg <= s3_next;
    end

endmodule

// File: rtl/bre_queue.sv
// Short queue of normalized jobs between the front end and the byte sequencer.
`timescale 1ns / 1ps

module bre_queue #(
    parameter int DEPTH = bre_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bre_pkg::job_t     push_job,
    input  logic              pop,
    output bre_pkg::job_t     rd_job,
    output bre_pkg::q_stat_t  q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bre_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign rd_job       = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: rtl/bre_back.sv
// Back end: walks one job byte by byte into the registered output word.
`timescale 1ns / 1ps

module bre_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bre_pkg::q_stat_t  q_stat,
    input  bre_pkg::job_t     rd_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              last,
    output logic              error
);

    localparam logic [bre_pkg::IDX_W-1:0] IDX_TAG = 4'd0;
    localparam logic [bre_pkg::IDX_W-1:0] IDX_LEN = 4'd1;
    localparam logic [bre_pkg::IDX_W-1:0] IDX_HDR = 4'd2;
    localparam logic [bre_pkg::IDX_W-1:0] IDX_EXP = 4'd3;

    bre_pkg::job_t               job_reg;
    logic                        busy_reg, busy_next;
    logic                        two_reg;      // exponent takes two bytes
    logic [bre_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [bre_pkg::IDX_W-1:0]   last_idx_reg, last_idx_load;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg;
    logic                        last_reg, error_reg;

    logic signed [bre_pkg::EXPO_W-1:0] rd_expo;
    logic        two_load;
    logic        out_take, gen, cur_last, done, load;
    logic [7:0]  byte_val;
    logic        err_val;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    assign rd_expo  = rd_job.expo;
    assign two_load = (rd_expo < bre_pkg::EXPO_ONE_MIN) || (rd_expo > bre_pkg::EXPO_ONE_MAX);

    always_comb
    begin
        case (rd_job.kind)
            bre_pkg::KIND_NUM: last_idx_load = 4'd3 + {3'b000, two_load} + {1'b0, rd_job.len_m};
            bre_pkg::KIND_INF: last_idx_load = IDX_HDR;
            default:           last_idx_load = IDX_TAG;
        endcase
    end

    assign out_take = !out_valid_reg || !out_stall;
    assign gen      = busy_reg && out_take;
    assign cur_last = (idx_reg == last_idx_reg);
    assign done     = gen && cur_last;
    assign load     = !q_stat.empty && (!busy_reg || done);
    assign pop      = load;

    // byte at the current position of the job
    always_comb
    begin
        logic [3:0]  j;
        logic [55:0] mant_pad;
        j        = last_idx_reg - idx_reg;
        mant_pad = {3'b000, job_reg.mant} >> {j[2:0], 3'b000};
        byte_val = '0;
        err_val  = 1'b0;
        case (job_reg.kind)
            bre_pkg::KIND_NUM:
            begin
                case (idx_reg)
                    IDX_TAG: byte_val = bre_pkg::TAG_REAL;
                    IDX_LEN: byte_val = 8'd2 + {7'b0, two_reg} + {5'b0, job_reg.len_m};
                    IDX_HDR: byte_val = bre_pkg::HDR_BINARY | {1'b0, job_reg.sign, 5'b0, two_reg};
                    IDX_EXP:
                    begin
                        if (two_reg)
                            byte_val = {job_reg.expo[bre_pkg::EXPO_W-1]
                                        ? bre_pkg::SIGN_FILL : 4'h0, job_reg.expo[11:8]};
                        else
                            byte_val = job_reg.expo[7:0];
                    end
                    default:
                    begin
                        if (two_reg && idx_reg == IDX_EXP + 1'b1)
                            byte_val = job_reg.expo[7:0];
                        else
                            byte_val = mant_pad[7:0];
                    end
                endcase
            end
            bre_pkg::KIND_INF:
            begin
                case (idx_reg)
                    IDX_TAG: byte_val = bre_pkg::TAG_REAL;
                    IDX_LEN: byte_val = bre_pkg::INF_LEN;
                    default: byte_val = bre_pkg::INF_PLUS | {7'b0, job_reg.sign};
                endcase
            end
            default:
            begin
                byte_val = '0;
                err_val  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (done)
            busy_next = 1'b0;
        else if (gen)
            idx_next = idx_reg + 1'b1;
        if (gen)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg      <= rd_job;
            two_reg      <= two_load;
            last_idx_reg <= last_idx_load;
        end
        if (gen)
        begin
            out_byte_reg <= byte_val;
            last_reg     <= cur_last;
            error_reg    <= err_val;
        end
    end

endmodule

// File: rtl/ber_real_double_encoder.sv
// Words pass the three normalize stages and the job queue before the byte sequencer.
// Throughput: one byte per cycle while out_stall is low; bytes per word:
//   1 for NaN, 3 for infinity, 5 to 12 for finite values, set by the byte sequencer.
// Three normalize stages and a small job queue let the next word enter while bytes drain.
// Reset: rst_n asynchronous, active low; clears stage valids, queue pointers and sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ber_real_double_encoder #(
    parameter int QUEUE_DEPTH = bre_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        error
);

    bre_pkg::q_stat_t q_stat;
    bre_pkg::job_t    push_job, rd_job;
    logic             push, pop;

    bre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_bits (value_bits),
        .q_stat     (q_stat),
        .push       (push),
        .push_job   (push_job)
    );

    bre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .rd_job   (rd_job),
        .q_stat   (q_stat)
    );

    bre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_job    (rd_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .error     (error)
    );

    // NaN word is a lone zero byte
    `ASSERT_IMPL(a_nan_single, out_valid && error, last && out_byte == '0)
    `ASSERT_IMPL(a_err_only_last, out_valid && !last, !error)
    `ASSERT_NEVER(a_q_full_empty, q_stat.full && q_stat.empty)

endmodule

// File: sim/tb_top.sv
// Self-checking bench for the BER REAL binary64 encoder: a table of words, then a random mix.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_DIR     = 24;
    localparam int NUM_RAND    = 96;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_DRAIN   = 20;
    localparam int MAX_REPORTS = 10;

    // one encoded output byte as it should appear on the result port
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       err;
    } enc_byte_t;

    // table row: n_typed == 0 means the predictor supplies the bytes
    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  n_typed;
        logic [95:0] typed;
        logic        typed_err;
    } dir_row_t;

    typedef enum int {
        VK_NORMAL,
        VK_TRAIL,
        VK_SUBNORM,
        VK_ZERO,
        VK_INF,
        VK_NAN,
        VK_EXP_EDGE,
        VK_RAW,
        VK_COUNT
    } value_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] value_bits;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        error;

    enc_byte_t enc_bytes_due[$];
    enc_byte_t want_byte;
    int        fail_cnt = 0;
    int        bytes_checked = 0;
    int        words_sent;
    int        cycle_cnt = 0;
    int        hold_left = 0;
    bit        steady;
    int        kind_cnt [VK_COUNT];

    dir_row_t dir_rows [NUM_DIR] = '{
        {64'h0000_0000_0000_0000, 4'd5, 96'h09_03_80_FB_00, 1'b0},  // +0
        {64'h8000_0000_0000_0000, 4'd5, 96'h09_03_C0_FB_00, 1'b0},  // -0
        {64'h7FF0_0000_0000_0000, 4'd3, 96'h09_01_40, 1'b0},        // +inf
        {64'hFFF0_0000_0000_0000, 4'd3, 96'h09_01_41, 1'b0},        // -inf
        {64'h7FF8_0000_0000_0000, 4'd1, 96'h00, 1'b1},              // quiet NaN
        {64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 96'h00, 1'b1},              // all ones NaN
        {64'h7FF0_0000_0000_0001, 4'd1, 96'h00, 1'b1},              // smallest NaN payload
        {64'h0000_0000_0000_0001, 4'd0, 96'h0, 1'b0},               // min subnormal
        {64'h800F_FFFF_FFFF_FFFF, 4'd0, 96'h0, 1'b0},               // max subnormal, neg
        {64'h0008_0000_0000_0000, 4'd0, 96'h0, 1'b0},
        {64'h0010_0000_0000_0000, 4'd0, 96'h0, 1'b0},               // min normal
        {64'h7FEF_FFFF_FFFF_FFFF, 4'd0, 96'h0, 1'b0},               // max finite
        {64'hFFEF_FFFF_FFFF_FFFF, 4'd0, 96'h0, 1'b0},
        {64'h3FF0_0000_0000_0000, 4'd0, 96'h0, 1'b0},               // 1.0
        {64'hBFF0_0000_0000_0000, 4'd0, 96'h0, 1'b0},
        {64'h4000_0000_0000_0000, 4'd0, 96'h0, 1'b0},
        {64'h3FF0_0000_0000_0001, 4'd0, 96'h0, 1'b0},               // nothing to strip
        {64'h4820_0000_0000_0000, 4'd0, 96'h0, 1'b0},               // exponent 127
        {64'h4830_0000_0000_0000, 4'd0, 96'h0, 1'b0},               // exponent 128
        {64'h3830_0000_0000_0000, 4'd0, 96'h0, 1'b0},               // exponent -128
        {64'h3820_0000_0000_0000, 4'd0, 96'h0, 1'b0},               // exponent -129
        {64'h5555_5555_5555_5555, 4'd0, 96'h0, 1'b0},
        {64'hAAAA_AAAA_AAAA_AAAA, 4'd0, 96'h0, 1'b0},
        {64'h4060_0000_0000_0000, 4'd0, 96'h0, 1'b0}
    };

    ber_real_double_encoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_bits (value_bits),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic due_byte(input logic [7:0] data, input logic fin, input logic err);
        enc_byte_t e;
        e.data = data;
        e.fin  = fin;
        e.err  = err;
        enc_bytes_due.push_back(e);
    endtask

    // Encode one binary64 pattern into its BER REAL bytes.
    task automatic encode_binary64(input logic [63:0] v);
        logic        sgn;
        logic [10:0] bexp;
        logic [51:0] frac;
        logic [63:0] mant;
        logic [31:0] expo_bits;
        logic [7:0]  hdr;
        logic [7:0]  len_byte;
        int          expo;
        int          msb;
        int          len_e;
        int          len_m;
        int          i;
        sgn  = v[63];
        bexp = v[62:52];
        frac = v[51:0];
        if (bexp == bre_pkg::BEXP_MAX)
        begin
            if (frac != '0)
                due_byte(8'h00, 1'b1, 1'b1);
            else
            begin
                due_byte(bre_pkg::TAG_REAL, 1'b0, 1'b0);
                due_byte(bre_pkg::INF_LEN, 1'b0, 1'b0);
                due_byte(bre_pkg::INF_PLUS | {7'd0, sgn}, 1'b1, 1'b0);
            end
        end
        else
        begin
            if (bexp != '0)
            begin
                mant = {11'd0, 1'b1, frac};
                expo = int'(bexp);
                expo = expo - 1075;
            end
            else if (frac != '0)
            begin
                // subnormal: shift the top set bit up to the hidden-bit slot
                msb = 51;
                while (!frac[msb])
                    msb--;
                mant = {12'd0, frac} << (52 - msb);
                expo = msb - 1126;
            end
            else
            begin
                mant = '0;
                expo = -53;
            end
            for (i = 0; i < bre_pkg::MAX_STRIP && mant[7:0] == 8'd0; i++)
            begin
                mant = mant >> 8;
                expo = expo + 8;
            end
            len_e = 1;
            while (len_e < 4 && (expo < -(1 << (8 * len_e - 1))
                                 || expo >= (1 << (8 * len_e - 1))))
                len_e++;
            len_m = 1;
            while (len_m < 8 && (mant >> (8 * len_m)) != 64'd0)
                len_m++;
            expo_bits = 32'(expo);
            len_byte  = 8'(1 + len_e + len_m);
            hdr       = bre_pkg::HDR_BINARY;
            hdr[6]    = sgn;
            hdr[1:0]  = 2'(len_e - 1);
            due_byte(bre_pkg::TAG_REAL, 1'b0, 1'b0);
            due_byte(len_byte, 1'b0, 1'b0);
            due_byte(hdr, 1'b0, 1'b0);
            for (i = len_e - 1; i >= 0; i--)
                due_byte(expo_bits[8 * i +: 8], 1'b0, 1'b0);
            for (i = len_m - 1; i >= 0; i--)
                due_byte(mant[8 * i +: 8], i == 0, 1'b0);
        end
    endtask

    task automatic send_word(input logic [63:0] v, input int n_typed, input logic [95:0] typed,
                             input logic typed_err);
        int k;
        in_valid   <= 1'b1;
        value_bits <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (n_typed == 0)
            encode_binary64(v);
        else
            for (k = 0; k < n_typed; k++)
                due_byte(typed[(n_typed - 1 - k) * 8 +: 8], k == n_typed - 1, typed_err);
        words_sent++;
    endtask

    task automatic idle_tx(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        while (enc_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] gen_binary64(input value_kind_t kind);
        logic [63:0] r64;
        logic [63:0] mask;
        logic [51:0] frac;
        logic [10:0] bexp;
        logic        sgn;
        r64  = {$urandom, $urandom};
        sgn  = 1'($urandom_range(0, 1));
        frac = r64[51:0];
        bexp = 11'($urandom_range(1, 2046));
        case (kind)
            VK_TRAIL:
            begin
                mask = ~((64'd1 << (8 * $urandom_range(0, 7))) - 64'd1);
                frac = frac & mask[51:0];
            end
            VK_SUBNORM:
            begin
                bexp = '0;
                frac = frac >> $urandom_range(0, 51);
                if (frac == '0)
                    frac = 52'd1;
            end
            VK_ZERO:
            begin
                bexp = '0;
                frac = '0;
            end
            VK_INF:
            begin
                bexp = bre_pkg::BEXP_MAX;
                frac = '0;
            end
            VK_NAN:
            begin
                bexp = bre_pkg::BEXP_MAX;
                if (frac == '0)
                    frac[$urandom_range(0, 51)] = 1'b1;
            end
            VK_EXP_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0: bexp = 11'd1;
                    1: bexp = 11'd2046;
                    2: bexp = 11'($urandom_range(1150, 1160));
                    3: bexp = 11'($urandom_range(890, 905));
                    4: bexp = 11'd1023;
                    default: bexp = 11'($urandom_range(1, 60));
                endcase
                mask = ~((64'd1 << (8 * $urandom_range(0, 7))) - 64'd1);
                frac = frac & mask[51:0];
            end
            VK_RAW:
                return r64;
            default: ;
        endcase
        return {sgn, bexp, frac};
    endfunction

    function automatic value_kind_t pick_kind();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return VK_NORMAL;
        if (sel < 48) return VK_TRAIL;
        if (sel < 60) return VK_SUBNORM;
        if (sel < 65) return VK_ZERO;
        if (sel < 70) return VK_INF;
        if (sel < 77) return VK_NAN;
        if (sel < 88) return VK_EXP_EDGE;
        return VK_RAW;
    endfunction

    // receiver back-pressure: bursts of stall, mostly short
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else if (!steady && $urandom_range(0, 3) == 0)
            hold_left = pick_gap();
        out_stall <= (hold_left > 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (enc_bytes_due.size() == 0)
                report_fail($sformatf("unexpected word: byte %02h last %b err %b",
                                      out_byte, last, error));
            else
            begin
                want_byte = enc_bytes_due.pop_front();
                bytes_checked++;
                if (out_byte !== want_byte.data || last !== want_byte.fin
                    || error !== want_byte.err)
                    report_fail($sformatf("mismatch: got %02h/%b/%b want %02h/%b/%b",
                                          out_byte, last, error, want_byte.data,
                                          want_byte.fin, want_byte.err));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding", cycle_cnt,
                     enc_bytes_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        value_kind_t kind;
        int          n;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        value_bits    = '0;
        steady        = 1'b0;
        words_sent    = 0;
        foreach (kind_cnt[j])
            kind_cnt[j] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            send_word(dir_rows[r].value, dir_rows[r].n_typed, dir_rows[r].typed,
                      dir_rows[r].typed_err);
            if ($urandom_range(0, 2) == 0)
                idle_tx(pick_gap());
        end
        // hold off the sender until the table has fully drained
        in_valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        for (n = 0; n < NUM_RAND; n++)
        begin
            steady = (n >= 50 && n < 80);
            kind   = pick_kind();
            kind_cnt[kind]++;
            send_word(gen_binary64(kind), 0, '0, 1'b0);
            if (n == 90)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            else if (!steady && $urandom_range(0, 2) == 0)
                idle_tx(pick_gap());
        end
        steady = 1'b0;
        in_valid <= 1'b0;
        wait_drained();
        repeat (END_DRAIN) @(posedge clk);
        if (enc_bytes_due.size() != 0)
            report_fail($sformatf("%0d bytes never arrived", enc_bytes_due.size()));

        $display("%0d words sent (%0d from table), %0d bytes compared, %0d failures",
                 words_sent, NUM_DIR, bytes_checked, fail_cnt);
        $display("random mix: normal %0d, trailing-zero %0d, subnormal %0d, zero %0d,",
                 kind_cnt[VK_NORMAL], kind_cnt[VK_TRAIL], kind_cnt[VK_SUBNORM],
                 kind_cnt[VK_ZERO], " inf %0d, nan %0d, exp-edge %0d, raw %0d",
                 kind_cnt[VK_INF], kind_cnt[VK_NAN],
                 kind_cnt[VK_EXP_EDGE], kind_cnt[VK_RAW]);
        if (fail_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
